@@ design/esed_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esed_pkg
// shared types, register indexes, reset values and the quadrature table
// ----------------------------------------------------------------------------
package esed_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_TORQUE_MAX        = 3'd0;
    localparam logic [2:0] REG_TORQUE_FAST_STEP  = 3'd1;
    localparam logic [2:0] REG_TORQUE_SLOW_STEP  = 3'd2;
    localparam logic [2:0] REG_SPEED_MAX         = 3'd3;
    localparam logic [2:0] REG_SPEED_FAST_STEP   = 3'd4;
    localparam logic [2:0] REG_SPEED_SLOW_STEP   = 3'd5;
    localparam logic [2:0] REG_FAST_WINDOW_US    = 3'd6;
    localparam logic [2:0] REG_BUTTON_HOLDOFF_US = 3'd7;

    // reset values (torque in hundredths of a newton metre)
    localparam logic [12:0] RST_TORQUE_MAX        = 13'd5000;
    localparam logic [9:0]  RST_TORQUE_FAST_STEP  = 10'd50;
    localparam logic [9:0]  RST_TORQUE_SLOW_STEP  = 10'd5;
    localparam logic [11:0] RST_SPEED_MAX         = 12'd3000;
    localparam logic [9:0]  RST_SPEED_FAST_STEP   = 10'd30;
    localparam logic [9:0]  RST_SPEED_SLOW_STEP   = 10'd3;
    localparam logic [19:0] RST_FAST_WINDOW_US    = 20'd25000;
    localparam logic [20:0] RST_BUTTON_HOLDOFF_US = 21'd200000;
    localparam logic [1:0]  RST_PREV_PINS         = 2'b11;

    typedef struct packed {
        logic [12:0] torque_max;
        logic [9:0]  torque_fast_step;
        logic [9:0]  torque_slow_step;
        logic [11:0] speed_max;
        logic [9:0]  speed_fast_step;
        logic [9:0]  speed_slow_step;
        logic [19:0] fast_window_us;
        logic [20:0] button_holdoff_us;
    } t_cfg;

    typedef enum logic [1:0] {
        DIR_HOLD,
        DIR_CW,
        DIR_CCW
    } t_dir;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_UP,
        EV_DOWN
    } t_event;

    // classified word passed from front to back
    typedef struct packed {
        t_event event_kind;
        logic   fast;
        logic   step_channel;
        logic   out_channel;
    } t_qentry;

    // quadrature transition table, index is {previous a, previous b, a, b}
    function automatic t_dir quad_dir(input logic [3:0] idx);
        t_dir d;
        unique case (idx)
            4'd2, 4'd4, 4'd11, 4'd13: d = DIR_CW;
            4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_CCW;
            default:                  d = DIR_HOLD;
        endcase
        return d;
    endfunction

endpackage

@@ design/esed_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esed_front
// accepts pin samples, counts detents and classifies each word
// ----------------------------------------------------------------------------
module esed_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_pin_a,
    input  logic                 i_pin_b,
    input  logic                 i_button_level,
    input  logic [31:0]          i_time_us,
    input  esed_pkg::t_cfg       i_cfg,
    output esed_pkg::t_qentry    o_entry
);

    logic [1:0]        r_prev_pins;
    logic signed [3:0] r_detent;
    logic              r_channel;
    logic [31:0]       r_last_up;
    logic [31:0]       r_last_down;
    logic [31:0]       r_last_press;

    esed_pkg::t_dir     w_dir;
    logic signed [3:0]  w_sum;
    logic [31:0]        w_up_elapsed;
    logic [31:0]        w_down_elapsed;
    logic [31:0]        w_press_elapsed;
    logic               w_up;
    logic               w_down;
    logic               w_toggle;

    assign w_dir = esed_pkg::quad_dir({r_prev_pins, i_pin_a, i_pin_b});

    always_comb begin
        unique case (w_dir)
            esed_pkg::DIR_CW:  w_sum = r_detent + 4'sd1;
            esed_pkg::DIR_CCW: w_sum = r_detent - 4'sd1;
            default:           w_sum = r_detent;
        endcase
    end

    assign w_up   = (w_sum > 4'sd3);
    assign w_down = (w_sum < -4'sd3);

    assign w_up_elapsed    = i_time_us - r_last_up;
    assign w_down_elapsed  = i_time_us - r_last_down;
    assign w_press_elapsed = i_time_us - r_last_press;
    assign w_toggle        = !i_button_level &&
                             (w_press_elapsed > {11'd0, i_cfg.button_holdoff_us});

    always_comb begin
        o_entry.step_channel = r_channel;
        o_entry.out_channel  = r_channel ^ w_toggle;
        if (w_up) begin
            o_entry.event_kind = esed_pkg::EV_UP;
            o_entry.fast       = (w_up_elapsed < {12'd0, i_cfg.fast_window_us});
        end else if (w_down) begin
            o_entry.event_kind = esed_pkg::EV_DOWN;
            o_entry.fast       = (w_down_elapsed < {12'd0, i_cfg.fast_window_us});
        end else begin
            o_entry.event_kind = esed_pkg::EV_NONE;
            o_entry.fast       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pins  <= esed_pkg::RST_PREV_PINS;
            r_detent     <= 4'sd0;
            r_channel    <= 1'b0;
            r_last_up    <= 32'd0;
            r_last_down  <= 32'd0;
            r_last_press <= 32'd0;
        end else if (i_accept) begin
            r_prev_pins <= {i_pin_a, i_pin_b};
            r_detent    <= (w_up || w_down) ? 4'sd0 : w_sum;
            if (w_up) begin
                r_last_up <= i_time_us;
            end
            if (w_down) begin
                r_last_down <= i_time_us;
            end
            if (w_toggle) begin
                r_channel    <= ~r_channel;
                r_last_press <= i_time_us;
            end
        end
    end

endmodule

@@ design/esed_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esed_queue
// small register fifo between front and back
// ----------------------------------------------------------------------------
module esed_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  esed_pkg::t_qentry i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output esed_pkg::t_qentry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    esed_pkg::t_qentry r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/esed_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esed_back
// applies detent steps and ceilings, holds the result word
// ----------------------------------------------------------------------------
module esed_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  esed_pkg::t_qentry i_q_head,
    output logic              o_pop,
    input  esed_pkg::t_cfg    i_cfg,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [12:0]       o_torque_setpoint,
    output logic [11:0]       o_speed_setpoint,
    output logic              o_channel_select
);

    logic        r_out_valid;
    logic [12:0] r_torque;
    logic [11:0] r_speed;
    logic        r_channel;

    logic [12:0] n_torque;
    logic [12:0] w_speed_wide;
    logic [11:0] n_speed;
    esed_pkg::t_event w_torque_ev;
    esed_pkg::t_event w_speed_ev;

    // one detent step, then the ceiling
    function automatic logic [12:0] apply_step(
        input logic [12:0]      v,
        input logic [12:0]      mx,
        input logic [9:0]       st,
        input logic             fast,
        input esed_pkg::t_event ev
    );
        logic [13:0] sum;
        logic [12:0] res;
        sum = {1'b0, v} + {4'd0, st};
        unique case (ev)
            esed_pkg::EV_UP: begin
                if (sum <= {1'b0, mx}) res = sum[12:0];
                else res = fast ? mx : v;
            end
            esed_pkg::EV_DOWN: begin
                if (v >= {3'd0, st}) res = v - {3'd0, st};
                else res = fast ? 13'd0 : v;
            end
            default: res = v;
        endcase
        if (res >= mx) res = mx;
        return res;
    endfunction

    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    assign w_torque_ev = i_q_head.step_channel ? esed_pkg::EV_NONE : i_q_head.event_kind;
    assign w_speed_ev  = i_q_head.step_channel ? i_q_head.event_kind : esed_pkg::EV_NONE;

    assign n_torque = apply_step(r_torque, i_cfg.torque_max,
                                 i_q_head.fast ? i_cfg.torque_fast_step
                                               : i_cfg.torque_slow_step,
                                 i_q_head.fast, w_torque_ev);
    assign w_speed_wide = apply_step({1'b0, r_speed}, {1'b0, i_cfg.speed_max},
                                     i_q_head.fast ? i_cfg.speed_fast_step
                                                   : i_cfg.speed_slow_step,
                                     i_q_head.fast, w_speed_ev);
    assign n_speed = w_speed_wide[11:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_torque    <= 13'd0;
            r_speed     <= 12'd0;
            r_channel   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_torque    <= n_torque;
                r_speed     <= n_speed;
                r_channel   <= i_q_head.out_channel;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_torque_setpoint = r_torque;
    assign o_speed_setpoint  = r_speed;
    assign o_channel_select  = r_channel;

endmodule

@@ design/encoder_setpoint_editor_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_setpoint_editor_core
// quadrature encoder setpoint editor with turn-speed dependent step size
// ----------------------------------------------------------------------------
// Each input word is one timestamped sample of encoder pins a and b and of the
// push button (low = pressed); each word gives exactly one result word with the
// torque setpoint (hundredths of a newton metre), the rpm setpoint and the
// channel being edited, all as they stand after that sample. Four quadrature
// transitions in one direction make a detent, which steps the edited channel
// by the fast step if the previous detent in that direction lies within
// fast_window_us, else by the slow step; fast steps clamp at 0 or the ceiling,
// slow steps that would cross a bound are dropped. A press toggles the channel
// at most once per button_holdoff_us. The block takes one word per clock,
// sustained, when the result side does not stall; a word's result goes from
// the front update into the queue at the accepting edge, then through the step
// and clamp in the back into the output register. The queue depth sets how
// many words the input may run ahead of a stalled output. Registers sit on an
// apb port at byte address 4*index and may only be changed while the block is
// idle.
// ----------------------------------------------------------------------------
module encoder_setpoint_editor_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // sample words in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_pin_a,
    input  logic        i_pin_b,
    input  logic        i_button_level,
    input  logic [31:0] i_time_us,

    // result words out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [12:0] o_torque_setpoint,
    output logic [11:0] o_speed_setpoint,
    output logic        o_channel_select,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    esed_pkg::t_cfg    r_cfg;
    esed_pkg::t_qentry w_entry;
    esed_pkg::t_qentry w_head;
    logic              w_accept;
    logic              w_q_full;
    logic              w_q_valid;
    logic              w_pop;
    logic              w_cfg_write;
    logic [2:0]        w_reg_idx;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    assign pready      = 1'b1;
    assign w_reg_idx   = paddr[4:2];
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.torque_max        <= esed_pkg::RST_TORQUE_MAX;
            r_cfg.torque_fast_step  <= esed_pkg::RST_TORQUE_FAST_STEP;
            r_cfg.torque_slow_step  <= esed_pkg::RST_TORQUE_SLOW_STEP;
            r_cfg.speed_max         <= esed_pkg::RST_SPEED_MAX;
            r_cfg.speed_fast_step   <= esed_pkg::RST_SPEED_FAST_STEP;
            r_cfg.speed_slow_step   <= esed_pkg::RST_SPEED_SLOW_STEP;
            r_cfg.fast_window_us    <= esed_pkg::RST_FAST_WINDOW_US;
            r_cfg.button_holdoff_us <= esed_pkg::RST_BUTTON_HOLDOFF_US;
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                esed_pkg::REG_TORQUE_MAX:        r_cfg.torque_max        <= pwdata[12:0];
                esed_pkg::REG_TORQUE_FAST_STEP:  r_cfg.torque_fast_step  <= pwdata[9:0];
                esed_pkg::REG_TORQUE_SLOW_STEP:  r_cfg.torque_slow_step  <= pwdata[9:0];
                esed_pkg::REG_SPEED_MAX:         r_cfg.speed_max         <= pwdata[11:0];
                esed_pkg::REG_SPEED_FAST_STEP:   r_cfg.speed_fast_step   <= pwdata[9:0];
                esed_pkg::REG_SPEED_SLOW_STEP:   r_cfg.speed_slow_step   <= pwdata[9:0];
                esed_pkg::REG_FAST_WINDOW_US:    r_cfg.fast_window_us    <= pwdata[19:0];
                esed_pkg::REG_BUTTON_HOLDOFF_US: r_cfg.button_holdoff_us <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        unique case (w_reg_idx)
            esed_pkg::REG_TORQUE_MAX:        prdata = {19'd0, r_cfg.torque_max};
            esed_pkg::REG_TORQUE_FAST_STEP:  prdata = {22'd0, r_cfg.torque_fast_step};
            esed_pkg::REG_TORQUE_SLOW_STEP:  prdata = {22'd0, r_cfg.torque_slow_step};
            esed_pkg::REG_SPEED_MAX:         prdata = {20'd0, r_cfg.speed_max};
            esed_pkg::REG_SPEED_FAST_STEP:   prdata = {22'd0, r_cfg.speed_fast_step};
            esed_pkg::REG_SPEED_SLOW_STEP:   prdata = {22'd0, r_cfg.speed_slow_step};
            esed_pkg::REG_FAST_WINDOW_US:    prdata = {12'd0, r_cfg.fast_window_us};
            esed_pkg::REG_BUTTON_HOLDOFF_US: prdata = {11'd0, r_cfg.button_holdoff_us};
            default:                         prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------------
    // front: detent counting, direction stamps, button holdoff
    // the front only stalls when the queue is full
    // ------------------------------------------------------------------------
    assign o_in_stall = w_q_full;
    assign w_accept   = i_in_valid && !w_q_full;

    esed_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_pin_a        (i_pin_a),
        .i_pin_b        (i_pin_b),
        .i_button_level (i_button_level),
        .i_time_us      (i_time_us),
        .i_cfg          (r_cfg),
        .o_entry        (w_entry)
    );

    // ------------------------------------------------------------------------
    // queue of classified words, lets front and back stall independently
    // ------------------------------------------------------------------------
    esed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    // ------------------------------------------------------------------------
    // back: setpoint arithmetic and the output register
    // ------------------------------------------------------------------------
    esed_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .i_q_head          (w_head),
        .o_pop             (w_pop),
        .i_cfg             (r_cfg),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_torque_setpoint (o_torque_setpoint),
        .o_speed_setpoint  (o_speed_setpoint),
        .o_channel_select  (o_channel_select)
    );

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // the front never pushes into a full queue
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_accept)
        else $error("word accepted while queue full");

    // a popped word always lands in the output register
    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_out_valid)
        else $error("popped word produced no result");

    // delivered setpoints never exceed their ceilings
    a_torque_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_torque_setpoint <= r_cfg.torque_max))
        else $error("torque setpoint above ceiling");

    a_speed_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_speed_setpoint <= r_cfg.speed_max))
        else $error("speed setpoint above ceiling");

endmodule
